// ----- rtl/bpfr_pkg.sv -----
// Shared types and constants of the buffer pool frame replacer.
package bpfr_pkg;

    localparam int unsigned NUM_FRAMES = 16;
    localparam int unsigned FRAME_BITS = 4;
    localparam int unsigned FILL_BITS  = 5;
    localparam int unsigned PAGE_BITS  = 24;
    localparam int unsigned PIN_BITS   = 8;
    localparam int unsigned CNT_BITS   = 32;

    localparam logic [PIN_BITS-1:0]  PIN_MAX = '1;
    localparam logic                 RS_LRU  = 1'b1;
    localparam logic [PAGE_BITS-1:0] NO_PAGE = '0;

    // Operation codes
    localparam logic [2:0] MODE_PIN   = 3'd0;
    localparam logic [2:0] MODE_UNPIN = 3'd1;
    localparam logic [2:0] MODE_DIRTY = 3'd2;
    localparam logic [2:0] MODE_FORCE = 3'd3;
    localparam logic [2:0] MODE_FLUSH = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ALL_PINNED = 3'd1;
    localparam logic [2:0] ST_NOT_RES    = 3'd2;
    localparam logic [2:0] ST_PINNED     = 3'd3;
    localparam logic [2:0] ST_NOT_PINNED = 3'd4;

    // Register addresses
    localparam logic [2:0] ADDR_POLICY = 3'd0;
    localparam logic [2:0] ADDR_FRAMES = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_ACT,
        S_MISS,
        S_VICT,
        S_FIND,
        S_SHIFT,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic                 lru;
        logic [FILL_BITS-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic [CNT_BITS-1:0]   writes_total;
        logic [CNT_BITS-1:0]   reads_total;
        logic [PIN_BITS-1:0]   pin_count_after;
        logic [PAGE_BITS-1:0]  write_page;
        logic                  write_back;
        logic                  read_request;
        logic [2:0]            status;
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_index;
    } t_result;

endpackage

// ----- rtl/bpfr_cfg.sv -----
// Configuration registers with APB-style access.
module bpfr_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output bpfr_pkg::t_cfg    o_cfg
);
    import bpfr_pkg::*;

    logic                 r_policy;
    logic [FILL_BITS-1:0] r_frames;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
            r_frames <= FILL_BITS'(NUM_FRAMES);
        end else if (wr_en) begin
            if (paddr == ADDR_POLICY) r_policy <= pwdata[0];
            if (paddr == ADDR_FRAMES) r_frames <= pwdata[FILL_BITS-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        case (paddr)
            ADDR_POLICY: prdata = {31'd0, r_policy};
            ADDR_FRAMES: prdata = {{(32-FILL_BITS){1'b0}}, r_frames};
            default:     prdata = '0;
        endcase
    end

    // clamp the fill limit to 1..NUM_FRAMES
    always_comb begin
        o_cfg.lru = r_policy;
        if (r_frames == '0)
            o_cfg.limit = FILL_BITS'(1);
        else if (r_frames > FILL_BITS'(NUM_FRAMES))
            o_cfg.limit = FILL_BITS'(NUM_FRAMES);
        else
            o_cfg.limit = r_frames;
    end

endmodule

// ----- rtl/bpfr_engine.sv -----
// Frame table and the sequencer that walks it one frame per cycle, unless a held result stalls it.
module bpfr_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bpfr_pkg::t_cfg              i_cfg,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [2:0]                  i_req_mode,
    input  logic [bpfr_pkg::PAGE_BITS-1:0] i_req_page,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output bpfr_pkg::t_result           o_res,
    output logic                        o_res_last
);
    import bpfr_pkg::*;

    t_state r_state, n_state;

    logic [PAGE_BITS-1:0]  r_tag  [NUM_FRAMES];
    logic [PIN_BITS-1:0]   r_pins [NUM_FRAMES];
    logic [FRAME_BITS-1:0] r_age  [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] r_valid, r_dirty;
    logic [FILL_BITS-1:0]  r_filled;
    logic [CNT_BITS-1:0]   r_rcnt, r_wcnt;

    logic [2:0]            r_mode;
    logic [PAGE_BITS-1:0]  r_page;
    logic [FRAME_BITS-1:0] r_idx, n_idx;
    logic [FRAME_BITS-1:0] r_f, n_f;

    logic                  r_ovalid;
    t_result               r_ores;
    logic                  r_olast;

    // datapath controls
    logic                  out_free;
    logic                  emit;
    t_result               e_res;
    logic                  e_last;
    logic                  rd_inc, wr_inc;
    logic                  pins_we;
    logic [FRAME_BITS-1:0] pins_addr;
    logic [PIN_BITS-1:0]   pins_data;
    logic                  tag_we;
    logic [FRAME_BITS-1:0] tag_addr;
    logic                  dirty_set, dirty_clr;
    logic [FRAME_BITS-1:0] dirty_addr;
    logic                  fill;
    logic                  age_we;
    logic [FRAME_BITS-1:0] age_addr, age_data;

    logic                  look_hit;
    logic [PIN_BITS-1:0]   pf;
    logic [FRAME_BITS-1:0] fa;
    logic                  at_end;
    logic                  shift_more;
    logic [NUM_FRAMES-1:0] flush_mask, above_mask;

    assign out_free   = !r_ovalid || i_res_ready;
    assign look_hit   = r_valid[r_idx] && (r_tag[r_idx] == r_page);
    assign pf         = r_pins[r_f];
    assign fa         = r_age[r_idx];
    assign at_end     = ({1'b0, r_idx} + FILL_BITS'(1)) >= r_filled;
    assign shift_more = ({1'b0, r_idx} + FILL_BITS'(1)) < r_filled;
    assign flush_mask = r_valid & r_dirty;
    assign above_mask = flush_mask & ~((NUM_FRAMES'(2) << r_idx) - NUM_FRAMES'(1));

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_ovalid;
    assign o_res       = r_ores;
    assign o_res_last  = r_olast;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_mode <= MODE_FORCE)      n_state = S_LOOK;
                    else if (i_req_mode == MODE_FLUSH) n_state = S_FLUSH;
                end
            end
            S_LOOK: begin
                if (look_hit)                             n_state = S_ACT;
                else if (r_idx == FRAME_BITS'(NUM_FRAMES-1)) n_state = S_MISS;
            end
            S_ACT: begin
                if (out_free)
                    n_state = (r_mode == MODE_PIN && i_cfg.lru == RS_LRU) ? S_FIND : S_IDLE;
            end
            S_MISS: begin
                if (out_free) begin
                    if (r_mode == MODE_PIN && r_filled >= i_cfg.limit) n_state = S_VICT;
                    else                                               n_state = S_IDLE;
                end
            end
            S_VICT: begin
                if (r_pins[fa] == '0) begin
                    if (out_free) n_state = S_SHIFT;
                end else if (at_end) begin
                    if (out_free) n_state = S_IDLE;
                end
            end
            S_FIND: begin
                if (fa == r_f)    n_state = S_SHIFT;
                else if (at_end)  n_state = S_IDLE;
            end
            S_SHIFT: begin
                if (!shift_more) n_state = S_IDLE;
            end
            S_FLUSH: begin
                if (flush_mask[r_idx]) begin
                    if (out_free && above_mask == '0) n_state = S_IDLE;
                end else if (r_idx == FRAME_BITS'(NUM_FRAMES-1)) begin
                    if (out_free) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_idx      = r_idx;
        n_f        = r_f;
        emit       = 1'b0;
        e_res      = '0;
        e_last     = 1'b1;
        rd_inc     = 1'b0;
        wr_inc     = 1'b0;
        pins_we    = 1'b0;
        pins_addr  = r_f;
        pins_data  = '0;
        tag_we     = 1'b0;
        tag_addr   = r_f;
        dirty_set  = 1'b0;
        dirty_clr  = 1'b0;
        dirty_addr = r_f;
        fill       = 1'b0;
        age_we     = 1'b0;
        age_addr   = r_idx;
        age_data   = r_f;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
            end
            S_LOOK: begin
                if (look_hit) n_f = r_idx;
                else          n_idx = r_idx + FRAME_BITS'(1);
            end
            S_ACT: begin
                e_res.frame_index = r_f;
                e_res.hit         = 1'b1;
                e_res.pin_count_after = pf;
                case (r_mode)
                    MODE_PIN: begin
                        pins_data = (pf == PIN_MAX) ? pf : pf + PIN_BITS'(1);
                        pins_we   = 1'b1;
                        e_res.pin_count_after = pins_data;
                    end
                    MODE_UNPIN: begin
                        if (pf == '0) begin
                            e_res.status = ST_NOT_PINNED;
                        end else begin
                            pins_data = pf - PIN_BITS'(1);
                            pins_we   = 1'b1;
                            e_res.pin_count_after = pins_data;
                        end
                    end
                    MODE_DIRTY: dirty_set = 1'b1;
                    default: begin
                        if (pf != '0) begin
                            e_res.status = ST_PINNED;
                        end else begin
                            dirty_clr        = 1'b1;
                            wr_inc           = 1'b1;
                            e_res.write_back = 1'b1;
                            e_res.write_page = r_page;
                        end
                    end
                endcase
                emit = out_free;
                n_idx = '0;
            end
            S_MISS: begin
                if (r_mode != MODE_PIN) begin
                    e_res.status = ST_NOT_RES;
                end else if (r_filled < i_cfg.limit) begin
                    // free frame: fill in index order
                    fill      = 1'b1;
                    tag_we    = 1'b1;
                    tag_addr  = r_filled[FRAME_BITS-1:0];
                    pins_we   = 1'b1;
                    pins_addr = r_filled[FRAME_BITS-1:0];
                    pins_data = PIN_BITS'(1);
                    dirty_clr = 1'b1;
                    dirty_addr = r_filled[FRAME_BITS-1:0];
                    age_we    = 1'b1;
                    age_addr  = r_filled[FRAME_BITS-1:0];
                    age_data  = r_filled[FRAME_BITS-1:0];
                    rd_inc    = 1'b1;
                    e_res.frame_index     = r_filled[FRAME_BITS-1:0];
                    e_res.read_request    = 1'b1;
                    e_res.pin_count_after = PIN_BITS'(1);
                end
                emit = out_free && !(r_mode == MODE_PIN && r_filled >= i_cfg.limit);
                n_idx = '0;
            end
            S_VICT: begin
                if (r_pins[fa] == '0) begin
                    // evict the oldest unpinned frame
                    n_f       = fa;
                    tag_we    = 1'b1;
                    tag_addr  = fa;
                    pins_we   = 1'b1;
                    pins_addr = fa;
                    pins_data = PIN_BITS'(1);
                    dirty_addr = fa;
                    rd_inc    = 1'b1;
                    if (r_dirty[fa]) begin
                        dirty_clr        = 1'b1;
                        wr_inc           = 1'b1;
                        e_res.write_back = 1'b1;
                        e_res.write_page = r_tag[fa];
                    end
                    e_res.frame_index     = fa;
                    e_res.read_request    = 1'b1;
                    e_res.pin_count_after = PIN_BITS'(1);
                    emit = out_free;
                end else if (at_end) begin
                    e_res.status = ST_ALL_PINNED;
                    emit = out_free;
                end else begin
                    n_idx = r_idx + FRAME_BITS'(1);
                end
                if (!out_free) begin
                    n_f = r_f;
                    tag_we = 1'b0; pins_we = 1'b0; dirty_clr = 1'b0;
                    rd_inc = 1'b0; wr_inc = 1'b0;
                end
            end
            S_FIND: begin
                if (fa != r_f && !at_end) n_idx = r_idx + FRAME_BITS'(1);
            end
            S_SHIFT: begin
                // close the gap, then put the frame at the newest place
                age_we = 1'b1;
                if (shift_more) begin
                    age_data = r_age[r_idx + FRAME_BITS'(1)];
                    n_idx    = r_idx + FRAME_BITS'(1);
                end else begin
                    age_data = r_f;
                end
            end
            S_FLUSH: begin
                dirty_addr = r_idx;
                if (flush_mask[r_idx]) begin
                    e_res.frame_index     = r_idx;
                    e_res.write_back      = 1'b1;
                    e_res.write_page      = r_tag[r_idx];
                    e_res.pin_count_after = r_pins[r_idx];
                    e_last = (above_mask == '0);
                    emit      = out_free;
                    dirty_clr = out_free;
                    wr_inc    = out_free;
                    if (out_free) n_idx = r_idx + FRAME_BITS'(1);
                end else if (r_idx == FRAME_BITS'(NUM_FRAMES-1)) begin
                    emit = out_free;
                end else begin
                    n_idx = r_idx + FRAME_BITS'(1);
                end
            end
            default: ;
        endcase
        if (r_state == S_ACT || r_state == S_MISS) begin
            if (!out_free) begin
                pins_we = 1'b0; tag_we = 1'b0; dirty_set = 1'b0; dirty_clr = 1'b0;
                fill = 1'b0; age_we = 1'b0; rd_inc = 1'b0; wr_inc = 1'b0;
            end
        end
        e_res.reads_total  = r_rcnt + CNT_BITS'(rd_inc);
        e_res.writes_total = r_wcnt + CNT_BITS'(wr_inc);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_dirty  <= '0;
            r_filled <= '0;
            r_rcnt   <= '0;
            r_wcnt   <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NUM_FRAMES; k++) r_pins[k] <= '0;
        end else begin
            r_state <= n_state;
            if (pins_we) r_pins[pins_addr] <= pins_data;
            if (dirty_set) r_dirty[dirty_addr] <= 1'b1;
            if (dirty_clr) r_dirty[dirty_addr] <= 1'b0;
            if (fill) begin
                r_valid[r_filled[FRAME_BITS-1:0]] <= 1'b1;
                r_filled <= r_filled + FILL_BITS'(1);
            end
            if (rd_inc) r_rcnt <= r_rcnt + CNT_BITS'(1);
            if (wr_inc) r_wcnt <= r_wcnt + CNT_BITS'(1);
            if (emit)            r_ovalid <= 1'b1;
            else if (i_res_ready) r_ovalid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_f   <= n_f;
        if (r_state == S_IDLE && i_req_valid) begin
            r_mode <= i_req_mode;
            r_page <= i_req_page;
        end
        if (tag_we) r_tag[tag_addr] <= r_page;
        if (age_we) r_age[age_addr] <= age_data;
        if (emit) begin
            r_ores  <= e_res;
            r_olast <= e_last;
        end
    end

endmodule

// ----- rtl/buffer_pool_frame_replacer.sv -----
// Top level of the buffer pool frame replacer.
// Page-frame manager for a 16-frame buffer pool. Each request (tuser = mode,
// tdata = page) is handled by a sequencer that visits one frame per cycle with
// a single tag comparator, unless a held result stalls it. o_s_tready is high
// only while the sequencer is idle. The lookup visits the frames in index
// order up to the hit, or all 16 on a miss. After a pin miss with no free
// frame, the victim search and the shift of the age list follow. After a pin
// hit in LRU mode the age list is reordered. Flush all walks the frames up to
// the last dirty one and emits one result per dirty frame, or a single result
// if none is dirty. Results wait in an output register; while i_m_tready low
// holds that register, the sequencer stalls where it has a result to give.
module buffer_pool_frame_replacer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [23:0]   i_s_tdata,   // [23:0] page_number
    input  logic [2:0]    i_s_tuser,   // [2:0] mode
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [3:0] frame_index, [4] hit, [7:5] status, [8] read_request, [9] write_back,
    // [33:10] write_page, [41:34] pin_count_after, [73:42] reads_total,
    // [105:74] writes_total, [111:106] zero
    output logic [111:0]  o_m_tdata,
    output logic          o_m_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import bpfr_pkg::*;

    t_cfg    cfg;
    t_result res;

    bpfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bpfr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req_mode  (i_s_tuser),
        .i_req_page  (i_s_tdata[PAGE_BITS-1:0]),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res),
        .o_res_last  (o_m_tlast)
    );

    // result packing, frame_index lowest, six zero bits on top
    assign o_m_tdata = {6'd0, res};

endmodule

// ----- rtl/bpfr_checker.sv -----
// Port-level checks for the buffer pool frame replacer, bound to the top level.
module bpfr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_s_tvalid,
    input logic          o_s_tready,
    input logic [2:0]    i_s_tuser,
    input logic          o_m_tvalid,
    input logic          i_m_tready,
    input logic [111:0]  o_m_tdata,
    input logic          o_m_tlast
);
    import bpfr_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // one request at a time; unused modes are dropped at once
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser <= MODE_FLUSH) |=> !o_s_tready)
        else $error("request taken while busy");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // write_page is zero without write_back
    a_wpage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[9] |-> o_m_tdata[33:10] == '0)
        else $error("write page without write back");

    // error status ends the request
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[7:5] != ST_OK |-> o_m_tlast)
        else $error("error status not last");

endmodule

bind buffer_pool_frame_replacer bpfr_checker u_bpfr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the buffer pool frame replacer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bpfr_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        t_result r;
        logic    last;
    } t_expect;

    typedef struct {
        logic [2:0]  mode;
        logic [23:0] page;
        bit          typed;
        logic [3:0]  t_frame;
        logic [2:0]  t_status;
        logic [7:0]  t_pins;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    logic [23:0]   i_s_tdata;   // [23:0] page_number
    logic [2:0]    i_s_tuser;   // [2:0] mode
    logic          o_m_tvalid;
    logic          i_m_tready;
    logic [111:0]  o_m_tdata;   // frame_index .. writes_total, see t_result
    logic          o_m_tlast;
    logic          psel, penable, pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    buffer_pool_frame_replacer dut (.*);

    // Predictor state
    logic [23:0] pool_tag [NUM_FRAMES];
    bit          pool_valid [NUM_FRAMES];
    bit          pool_dirty [NUM_FRAMES];
    logic [7:0]  pool_pins [NUM_FRAMES];
    int unsigned pool_age [NUM_FRAMES];
    int unsigned pool_filled;
    logic [31:0] reads_seen, writes_seen;
    bit          cfg_lru;
    int unsigned cfg_frames;

    t_expect     pending_q[$];
    int          errors;
    int          idle_cycles;
    bit          no_gaps;
    logic [23:0] page_set[20];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Record one predicted result
    function automatic void push_result(int unsigned fr, bit hit, logic [2:0] st, bit rd,
                                        bit wb, logic [23:0] wpage, logic [7:0] pins,
                                        bit last);
        t_expect e;
        e.r = '0;
        e.r.frame_index = fr[3:0];
        e.r.hit = hit;
        e.r.status = st;
        e.r.read_request = rd;
        e.r.write_back = wb;
        e.r.write_page = wpage;
        e.r.pin_count_after = pins;
        e.r.reads_total = reads_seen;
        e.r.writes_total = writes_seen;
        e.last = last;
        pending_q.push_back(e);
    endfunction

    function automatic int find_frame(logic [23:0] page);
        for (int i = 0; i < NUM_FRAMES; i++)
            if (pool_valid[i] && pool_tag[i] == page) return i;
        return -1;
    endfunction

    function automatic void move_to_newest(int unsigned f);
        int unsigned p;
        p = 0;
        while (p < pool_filled && pool_age[p] != f) p++;
        if (p >= pool_filled) return;
        for (int unsigned q = p; q + 1 < pool_filled; q++) pool_age[q] = pool_age[q + 1];
        pool_age[pool_filled - 1] = f;
    endfunction

    // Expected results of one accepted request
    function automatic void predict_request(logic [2:0] mode, logic [23:0] page);
        int f;
        int unsigned lim, p, v, k;
        bit wb;
        logic [23:0] wpage;
        lim = cfg_frames < 1 ? 1 : (cfg_frames > NUM_FRAMES ? NUM_FRAMES : cfg_frames);
        f = find_frame(page);
        case (mode)
            MODE_PIN: begin
                if (f >= 0) begin
                    if (cfg_lru == RS_LRU) move_to_newest(f);
                    if (pool_pins[f] != PIN_MAX) pool_pins[f]++;
                    push_result(f, 1, ST_OK, 0, 0, NO_PAGE, pool_pins[f], 1);
                end else if (pool_filled < lim) begin
                    v = pool_filled;
                    pool_valid[v] = 1; pool_tag[v] = page; pool_dirty[v] = 0;
                    pool_pins[v] = 1; pool_age[v] = v;
                    pool_filled++;
                    reads_seen++;
                    push_result(v, 0, ST_OK, 1, 0, NO_PAGE, 1, 1);
                end else begin
                    p = 0;
                    while (p < pool_filled && pool_pins[pool_age[p]] != 0) p++;
                    if (p >= pool_filled) begin
                        push_result(0, 0, ST_ALL_PINNED, 0, 0, NO_PAGE, 0, 1);
                    end else begin
                        v = pool_age[p];
                        move_to_newest(v);
                        wb = pool_dirty[v];
                        wpage = wb ? pool_tag[v] : NO_PAGE;
                        if (wb) writes_seen++;
                        pool_dirty[v] = 0; pool_tag[v] = page; pool_pins[v] = 1;
                        reads_seen++;
                        push_result(v, 0, ST_OK, 1, wb, wpage, 1, 1);
                    end
                end
            end
            MODE_UNPIN, MODE_DIRTY, MODE_FORCE: begin
                if (f < 0)
                    push_result(0, 0, ST_NOT_RES, 0, 0, NO_PAGE, 0, 1);
                else if (mode == MODE_UNPIN) begin
                    if (pool_pins[f] == 0)
                        push_result(f, 1, ST_NOT_PINNED, 0, 0, NO_PAGE, 0, 1);
                    else begin
                        pool_pins[f]--;
                        push_result(f, 1, ST_OK, 0, 0, NO_PAGE, pool_pins[f], 1);
                    end
                end else if (mode == MODE_DIRTY) begin
                    pool_dirty[f] = 1;
                    push_result(f, 1, ST_OK, 0, 0, NO_PAGE, pool_pins[f], 1);
                end else if (pool_pins[f] != 0)
                    push_result(f, 1, ST_PINNED, 0, 0, NO_PAGE, pool_pins[f], 1);
                else begin
                    pool_dirty[f] = 0;
                    writes_seen++;
                    push_result(f, 1, ST_OK, 0, 1, page, 0, 1);
                end
            end
            MODE_FLUSH: begin
                k = 0;
                for (int i = 0; i < NUM_FRAMES; i++) begin
                    if (pool_valid[i] && pool_dirty[i]) begin
                        pool_dirty[i] = 0;
                        writes_seen++;
                        push_result(i, 0, ST_OK, 0, 1, pool_tag[i], pool_pins[i], 0);
                        k++;
                    end
                end
                if (k == 0) push_result(0, 0, ST_OK, 0, 0, NO_PAGE, 0, 1);
                else pending_q[$].last = 1;
            end
            default: ;  // unused modes are dropped
        endcase
    endfunction

    // Send one request; predicts at the edge where it is accepted
    task automatic send_request(logic [2:0] mode, logic [23:0] page);
        @(negedge i_clk);
        if (!no_gaps && $urandom_range(99) < 32) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = mode;
        i_s_tdata = page;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_request(mode, page);
    endtask

    // Register write while the pool is idle
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        wait (pending_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == ADDR_POLICY) cfg_lru = value[0];
        else cfg_frames = value[4:0];
    endtask

    function automatic logic [23:0] pick_page();
        if ($urandom_range(99) < 85) return page_set[$urandom_range(19)];
        return 24'($urandom());
    endfunction

    function automatic logic [2:0] pick_mode();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) return MODE_PIN;
        if (r < 62) return MODE_UNPIN;
        if (r < 75) return MODE_DIRTY;
        if (r < 86) return MODE_FORCE;
        if (r < 94) return MODE_FLUSH;
        return 3'($urandom_range(7, 5));
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Result checker and stall watchdog
    always @(posedge i_clk) begin
        t_result got;
        t_expect e;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = t_result'(o_m_tdata[$bits(t_result)-1:0]);
                if (pending_q.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end else begin
                    e = pending_q.pop_front();
                    check_field("frame_index", e.r.frame_index, got.frame_index);
                    check_field("hit", e.r.hit, got.hit);
                    check_field("status", e.r.status, got.status);
                    check_field("read_request", e.r.read_request, got.read_request);
                    check_field("write_back", e.r.write_back, got.write_back);
                    check_field("write_page", e.r.write_page, got.write_page);
                    check_field("pin_count_after", e.r.pin_count_after, got.pin_count_after);
                    check_field("reads_total", e.r.reads_total, got.reads_total);
                    check_field("writes_total", e.r.writes_total, got.writes_total);
                    check_field("last", e.last, o_m_tlast);
                end
            end
        end
    end

    // Output-side backpressure
    always @(negedge i_clk)
        i_m_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 32);

    initial begin
        t_row rows[$];
        int unsigned phase_policy[6] = '{1, 0, 1, 0, 1, 0};
        int unsigned phase_frames[6] = '{16, 1, 3, 0, 31, 8};
        int n;
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tuser = MODE_PIN;
        i_m_tready = 1'b1;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; idle_cycles = 0; no_gaps = 0;
        foreach (pool_valid[i]) begin
            pool_valid[i] = 0; pool_dirty[i] = 0; pool_pins[i] = '0;
            pool_tag[i] = '0; pool_age[i] = 0;
        end
        pool_filled = 0; reads_seen = '0; writes_seen = '0;
        cfg_lru = 0; cfg_frames = 16;
        foreach (page_set[i]) page_set[i] = 24'($urandom());
        page_set[0] = 24'h000000;
        page_set[1] = 24'hFFFFFF;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed requests: extremes, every mode, error codes
        rows = '{
            '{MODE_UNPIN, 24'h000005, 1, 4'd0, ST_NOT_RES, 8'd0},
            '{MODE_FLUSH, 24'h000000, 1, 4'd0, ST_OK, 8'd0},
            '{MODE_PIN,   24'h000000, 1, 4'd0, ST_OK, 8'd1},
            '{MODE_PIN,   24'hFFFFFF, 1, 4'd1, ST_OK, 8'd1},
            '{MODE_PIN,   24'h000000, 1, 4'd0, ST_OK, 8'd2},
            '{MODE_DIRTY, 24'hFFFFFF, 0, 4'd0, ST_OK, 8'd0},
            '{MODE_FORCE, 24'hFFFFFF, 1, 4'd1, ST_PINNED, 8'd1},
            '{MODE_UNPIN, 24'hFFFFFF, 1, 4'd1, ST_OK, 8'd0},
            '{MODE_UNPIN, 24'hFFFFFF, 1, 4'd1, ST_NOT_PINNED, 8'd0},
            '{MODE_FORCE, 24'hFFFFFF, 0, 4'd0, ST_OK, 8'd0},
            '{MODE_FORCE, 24'hFFFFFF, 0, 4'd0, ST_OK, 8'd0},
            '{MODE_DIRTY, 24'h000000, 0, 4'd0, ST_OK, 8'd0},
            '{MODE_DIRTY, 24'hFFFFFF, 0, 4'd0, ST_OK, 8'd0},
            '{MODE_FLUSH, 24'h123456, 0, 4'd0, ST_OK, 8'd0},
            '{3'd5,       24'hAAAAAA, 0, 4'd0, ST_OK, 8'd0},
            '{3'd6,       24'h555555, 0, 4'd0, ST_OK, 8'd0},
            '{3'd7,       24'hFFFFFF, 0, 4'd0, ST_OK, 8'd0},
            '{MODE_FORCE, 24'h800000, 1, 4'd0, ST_NOT_RES, 8'd0},
            '{MODE_DIRTY, 24'h000001, 1, 4'd0, ST_NOT_RES, 8'd0}
        };
        foreach (rows[i]) begin
            send_request(rows[i].mode, rows[i].page);
            if (rows[i].typed) begin
                pending_q[$].r.frame_index = rows[i].t_frame;
                pending_q[$].r.status = rows[i].t_status;
                pending_q[$].r.pin_count_after = rows[i].t_pins;
            end
        end

        // Repeated pins of one page, with no idling on either side
        no_gaps = 1;
        repeat (12) send_request(MODE_PIN, 24'hABCDEF);
        no_gaps = 0;

        // Random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ADDR_POLICY, phase_policy[ph]);
            write_reg(ADDR_FRAMES, phase_frames[ph]);
            n = 0;
            while (n < 16) begin
                logic [2:0] m;
                m = pick_mode();
                if (m <= MODE_FLUSH) n++;
                no_gaps = (ph == 2);
                send_request(m, pick_page());
            end
        end
        no_gaps = 0;

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        wait (pending_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/bpfr_pkg.sv
rtl/bpfr_cfg.sv
rtl/bpfr_engine.sv
rtl/buffer_pool_frame_replacer.sv
rtl/bpfr_checker.sv
test/tb_top.sv
